/* rtl/core/rom_bank_map_dma_snoop_macros.svh */
// Assertion macros used by the controller top level.
`ifndef ROM_BANK_MAP_DMA_SNOOP_MACROS_SVH
`define ROM_BANK_MAP_DMA_SNOOP_MACROS_SVH
`ifndef SYNTHESIS
`define RBMDS_ASSERT(label, clk, rst_n, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBMDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define RBMDS_ASSERT(label, clk, rst_n, prop, msg)
`define RBMDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/rbmds_pkg.sv */
// Types, codes and constants of the ROM bank map / DMA snoop controller.
package rbmds_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int BANKS        = 4;
	localparam int BANK_IDX_W   = $clog2(BANKS);

	typedef enum logic [2:0] {
		ACT_FORWARD = 3'd0,
		ACT_READ    = 3'd1,
		ACT_OPEN    = 3'd2,
		ACT_WRITE   = 3'd3,
		ACT_ROM     = 3'd4,
		ACT_DECOMP  = 3'd5
	} action_t;

	localparam logic [1:0] KIND_RD  = 2'd0;
	localparam logic [1:0] KIND_WR  = 2'd1;
	localparam logic [1:0] KIND_ROM = 2'd2;

	localparam logic [15:0] DMA_WIN_MASK = 16'h4380;
	localparam logic [15:0] DMA_WIN_BASE = 16'h4300;
	localparam logic [15:0] REG_DEV_EN   = 16'h4800;
	localparam logic [15:0] REG_XFER_EN  = 16'h4801;
	localparam logic [15:0] REG_BANK0    = 16'h4804;

	localparam logic [3:0] DMA_ADDR_LO  = 4'd2;
	localparam logic [3:0] DMA_ADDR_MID = 4'd3;
	localparam logic [3:0] DMA_ADDR_HI  = 4'd4;
	localparam logic [3:0] DMA_CNT_LO   = 4'd5;
	localparam logic [3:0] DMA_CNT_HI   = 4'd6;

	localparam logic [23:0] ROM_DIRECT_LIMIT = 24'h400000;
	localparam logic [23:0] BANK_OFS_MASK    = 24'h0fffff;

	// Register write strobes decoded from one item
	typedef struct packed {
		logic                  dma_wr;
		logic [2:0]            dma_ch;
		logic [3:0]            dma_ofs;
		logic                  dev_wr;
		logic                  xfer_wr;
		logic                  bank_wr;
		logic [BANK_IDX_W-1:0] bank_idx;
		logic [7:0]            data;
	} reg_wr_t;

	// Channel match result
	typedef struct packed {
		logic       hit;
		logic [2:0] chan;
		logic       start;
	} match_t;

endpackage

/* rtl/core/rom_bank_map_dma_snoop.sv */
// Top level of the cartridge memory controller with DMA snooping.
`include "rom_bank_map_dma_snoop_macros.svh"

// One bus access per item, one item accepted every clock cycle unless the input is
// stalled. An item is captured in an input register, decoded, matched against the
// channel table and mapped combinationally, and its result lands in a result register
// once the result register is free to take it. The channel match, count decrement and
// stream bookkeeping for an item complete as it moves into the result register, so the
// next item always sees the state the previous one left. Both sides may stall freely;
// accesses stay in order and no reset sweep is needed.
module rom_bank_map_dma_snoop
	import rbmds_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        access_valid,
	output logic        access_stall,
	input  logic [1:0]  kind,
	input  logic [23:0] address,
	input  logic [7:0]  write_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  action,
	output logic [7:0]  read_data,
	output logic [27:0] rom_address,
	output logic        stream_start,
	output logic [2:0]  channel
);

	logic        s1_valid_q;
	logic [1:0]  kind_s1;
	logic [23:0] address_s1;
	logic [7:0]  write_data_s1;
	logic        s1_fire;
	logic        result_valid_q;
	action_t     action_s2;
	logic [7:0]  read_data_s2;
	logic [27:0] rom_address_s2;
	logic        stream_start_s2;
	logic [2:0]  channel_s2;

	logic [15:0] a16;
	logic        in_dma;
	logic        is_bank;
	logic        below;
	logic        is_wr;
	logic        serve;
	reg_wr_t     wr;
	match_t      match;
	logic [7:0]  bank_rd;
	logic [27:0] map_rom;
	action_t     act_d;
	logic [7:0]  rd_d;
	logic [27:0] rom_d;
	logic        start_d;
	logic [2:0]  chan_d;

	assign s1_fire      = s1_valid_q & (~result_valid_q | ~result_stall);
	assign access_stall = s1_valid_q & ~s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!access_stall) begin
			s1_valid_q <= access_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (access_valid && !access_stall) begin
			kind_s1       <= kind;
			address_s1    <= address;
			write_data_s1 <= write_data;
		end
	end

	assign a16     = address_s1[15:0];
	assign in_dma  = (a16 & DMA_WIN_MASK) == DMA_WIN_BASE;
	assign is_bank = a16[15:BANK_IDX_W] == REG_BANK0[15:BANK_IDX_W];
	assign below   = address_s1 < ROM_DIRECT_LIMIT;
	assign is_wr   = s1_fire & (kind_s1 == KIND_WR);
	assign serve   = s1_fire & (kind_s1 == KIND_ROM) & ~below & match.hit;

	always_comb begin
		wr.dma_wr   = is_wr & in_dma;
		wr.dma_ch   = a16[6:4];
		wr.dma_ofs  = a16[3:0];
		wr.dev_wr   = is_wr & ~in_dma & (a16 == REG_DEV_EN);
		wr.xfer_wr  = is_wr & ~in_dma & (a16 == REG_XFER_EN);
		wr.bank_wr  = is_wr & ~in_dma & is_bank;
		wr.bank_idx = a16[BANK_IDX_W-1:0];
		wr.data     = write_data_s1;
	end

	rbmds_chan_table #(
		.CHANNELS(CHANNELS)
	) u_chan_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.address (address_s1),
		.serve   (serve),
		.match   (match)
	);

	rbmds_bank_map u_bank_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_idx   (a16[BANK_IDX_W-1:0]),
		.map_addr (address_s1),
		.rd_data  (bank_rd),
		.map_rom  (map_rom)
	);

	always_comb begin
		act_d   = ACT_OPEN;
		rd_d    = '0;
		rom_d   = '0;
		start_d = 1'b0;
		chan_d  = '0;
		case (kind_s1)
			KIND_RD: begin
				if (in_dma) begin
					act_d = ACT_FORWARD;
				end else if (is_bank) begin
					act_d = ACT_READ;
					rd_d  = bank_rd;
				end
			end
			KIND_WR: begin
				act_d = in_dma ? ACT_FORWARD : ACT_WRITE;
			end
			KIND_ROM: begin
				if (below) begin
					act_d = ACT_ROM;
					rom_d = {4'd0, address_s1};
				end else if (match.hit) begin
					act_d   = ACT_DECOMP;
					start_d = match.start;
					chan_d  = match.chan;
				end else begin
					act_d = ACT_ROM;
					rom_d = map_rom;
				end
			end
			default: act_d = ACT_OPEN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s1_fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			action_s2       <= act_d;
			read_data_s2    <= rd_d;
			rom_address_s2  <= rom_d;
			stream_start_s2 <= start_d;
			channel_s2      <= chan_d;
		end
	end

	assign result_valid = result_valid_q;
	assign action       = action_s2;
	assign read_data    = read_data_s2;
	assign rom_address  = rom_address_s2;
	assign stream_start = stream_start_s2;
	assign channel      = channel_s2;

	`RBMDS_ASSERT_IMP(a_stall_cause, clk, arst_n, access_stall, s1_valid_q && result_valid_q && result_stall, "input stalled without a blocked result")
	`RBMDS_ASSERT_IMP(a_no_bubble, clk, arst_n, !result_valid_q, !access_stall, "input stalled while result register is empty")
	`RBMDS_ASSERT_IMP(a_start_decomp, clk, arst_n, result_valid_q && stream_start_s2, action_s2 == ACT_DECOMP, "stream start on a non-decompressor result")
	`RBMDS_ASSERT_IMP(a_read_clean, clk, arst_n, result_valid_q && action_s2 != ACT_READ, read_data_s2 == 8'd0, "read data set outside a register read")

endmodule

/* rtl/core/rbmds_chan_table.sv */
// DMA channel table: snooped address and size, enable masks, priority match.
module rbmds_chan_table
	import rbmds_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  reg_wr_t     wr,
	input  logic [23:0] address,
	input  logic        serve,
	output match_t      match
);

	logic [23:0]         chan_addr_q [CHANNELS];
	logic [15:0]         chan_cnt_q  [CHANNELS];
	logic [15:0]         cnt_dec     [CHANNELS];
	logic [7:0]          dev_en_q;
	logic [7:0]          xfer_en_q;
	logic                active_q;
	logic [CHANNELS-1:0] cand;
	logic [CHANNELS-1:0] sel;
	logic [CHANNELS-1:0] cnt_end;
	logic                end_sel;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			cand[i]    = dev_en_q[i] & xfer_en_q[i] & (chan_addr_q[i] == address);
			cnt_dec[i] = chan_cnt_q[i] - 16'd1;
			cnt_end[i] = (cnt_dec[i] == 16'd0);
		end
	end

	// Lowest-numbered candidate wins
	always_comb begin
		sel        = '0;
		match.chan = 3'd0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				sel        = '0;
				sel[i]     = 1'b1;
				match.chan = 3'(i);
			end
		end
		match.hit   = |cand;
		match.start = ~active_q;
		end_sel     = |(sel & cnt_end);
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				chan_addr_q[g] <= '0;
				chan_cnt_q[g]  <= '0;
			end else if (serve && sel[g]) begin
				chan_cnt_q[g] <= cnt_dec[g];
			end else if (wr.dma_wr && wr.dma_ch == 3'(g)) begin
				case (wr.dma_ofs)
					DMA_ADDR_LO:  chan_addr_q[g][7:0]   <= wr.data;
					DMA_ADDR_MID: chan_addr_q[g][15:8]  <= wr.data;
					DMA_ADDR_HI:  chan_addr_q[g][23:16] <= wr.data;
					DMA_CNT_LO:   chan_cnt_q[g][7:0]    <= wr.data;
					DMA_CNT_HI:   chan_cnt_q[g][15:8]   <= wr.data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_en_q  <= '0;
			xfer_en_q <= '0;
			active_q  <= 1'b0;
		end else begin
			if (wr.dev_wr)
				dev_en_q <= wr.data;
			if (wr.xfer_wr) begin
				xfer_en_q <= wr.data;
			end else if (serve && end_sel) begin
				// drop the finished channel's transfer enable
				xfer_en_q <= xfer_en_q & ~8'(sel);
			end
			if (serve)
				active_q <= ~end_sel;
		end
	end

endmodule

/* rtl/core/rbmds_bank_map.sv */
// Bank registers: register readback and 1 MiB bank mapping of ROM reads.
module rbmds_bank_map
	import rbmds_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  reg_wr_t               wr,
	input  logic [BANK_IDX_W-1:0] rd_idx,
	input  logic [23:0]           map_addr,
	output logic [7:0]            rd_data,
	output logic [27:0]           map_rom
);

	logic [7:0] bank_q [BANKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANKS; i++)
				bank_q[i] <= 8'(i);
		end else if (wr.bank_wr) begin
			bank_q[wr.bank_idx] <= wr.data;
		end
	end

	assign rd_data = bank_q[rd_idx];
	assign map_rom = {bank_q[map_addr[20+BANK_IDX_W-1:20]], map_addr[19:0] & BANK_OFS_MASK[19:0]};

endmodule

/* sim/rom_bank_map_dma_snoop_tb.sv */
// Self-checking testbench for the cartridge memory controller with DMA snooping.
`timescale 1ns / 100ps

module rom_bank_map_dma_snoop_tb;
	import rbmds_pkg::*;

	localparam int CHANNELS   = CHANNELS_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD  = 250;
	localparam int PAUSE_STEP = 400;
	localparam int ITEM_GOAL  = 1500;

	localparam logic [1:0] KIND_NONE      = 2'd3;
	localparam logic [3:0] DMA_OFS_UNUSED = 4'hf;

	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] address;
		logic [7:0]  write_data;
		logic        pause;
	} access_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  read_data;
		logic [27:0] rom_address;
		logic        stream_start;
		logic [2:0]  channel;
		longint      stamp;
	} outcome_t;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        access_valid = 1'b0;
	logic        access_stall;
	logic [1:0]  kind = KIND_RD;
	logic [23:0] address = '0;
	logic [7:0]  write_data = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  action;
	logic [7:0]  read_data;
	logic [27:0] rom_address;
	logic        stream_start;
	logic [2:0]  channel;

	// controller state as the checker sees it
	logic [23:0] dma_src [CHANNELS];
	logic [15:0] dma_len [CHANNELS];
	logic [7:0]  dev_enable;
	logic [7:0]  xfer_mask;
	logic [7:0]  bank_reg [BANKS];
	logic        in_stream;

	access_t  access_q [$];
	outcome_t outcome_q [$];

	int stim_count;
	int accesses_taken;
	int held_cycles;
	int results_checked;
	int bytes_served;
	int streams_started;
	int mismatches;

	rom_bank_map_dma_snoop #(.CHANNELS(CHANNELS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.access_valid (access_valid),
		.access_stall (access_stall),
		.kind         (kind),
		.address      (address),
		.write_data   (write_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.action       (action),
		.read_data    (read_data),
		.rom_address  (rom_address),
		.stream_start (stream_start),
		.channel      (channel)
	);

	always #5 clk = ~clk;

	function automatic outcome_t predict_access(logic [1:0] k, logic [23:0] a, logic [7:0] d);
		outcome_t    r;
		logic [15:0] a16;
		logic [15:0] bank_ofs;
		logic [2:0]  ch;
		logic [7:0]  live;
		logic        hit;
		int          i;
		r = '0;
		r.action = ACT_OPEN;
		a16 = a[15:0];
		bank_ofs = a16 - REG_BANK0;
		ch = a16[6:4];
		live = dev_enable & xfer_mask;
		hit = 1'b0;
		case (k)
		KIND_RD: begin
			if ((a16 & DMA_WIN_MASK) == DMA_WIN_BASE) begin
				r.action = ACT_FORWARD;
			end else if (a16 >= REG_BANK0 && a16 <= REG_BANK0 + 16'(BANKS - 1)) begin
				r.action = ACT_READ;
				r.read_data = bank_reg[bank_ofs[1:0]];
			end
		end
		KIND_WR: begin
			if ((a16 & DMA_WIN_MASK) == DMA_WIN_BASE) begin
				r.action = ACT_FORWARD;
				if (int'(ch) < CHANNELS) begin
					case (a16[3:0])
					DMA_ADDR_LO:  dma_src[ch][7:0]   = d;
					DMA_ADDR_MID: dma_src[ch][15:8]  = d;
					DMA_ADDR_HI:  dma_src[ch][23:16] = d;
					DMA_CNT_LO:   dma_len[ch][7:0]   = d;
					DMA_CNT_HI:   dma_len[ch][15:8]  = d;
					default:      ;
					endcase
				end
			end else begin
				r.action = ACT_WRITE;
				if (a16 == REG_DEV_EN)
					dev_enable = d;
				else if (a16 == REG_XFER_EN)
					xfer_mask = d;
				else if (a16 >= REG_BANK0 && a16 <= REG_BANK0 + 16'(BANKS - 1))
					bank_reg[bank_ofs[1:0]] = d;
			end
		end
		KIND_ROM: begin
			if (a < ROM_DIRECT_LIMIT) begin
				r.action = ACT_ROM;
				r.rom_address = {4'h0, a};
			end else begin
				// lowest enabled channel with a matching source wins
				for (i = 0; i < CHANNELS; i++) begin
					if (!hit && live[i] && a == dma_src[i]) begin
						hit = 1'b1;
						r.action = ACT_DECOMP;
						r.channel = 3'(i);
						if (!in_stream) begin
							r.stream_start = 1'b1;
							in_stream = 1'b1;
						end
						dma_len[i] = dma_len[i] - 16'd1;
						if (dma_len[i] == 16'd0) begin
							in_stream = 1'b0;
							xfer_mask[i] = 1'b0;
						end
					end
				end
				if (!hit) begin
					r.action = ACT_ROM;
					r.rom_address = {bank_reg[a[21:20]], 20'h0} + {4'h0, a & BANK_OFS_MASK};
				end
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic push_access(logic [1:0] k, logic [23:0] a, logic [7:0] d);
		access_q.push_back('{k, a, d, 1'b0});
		if (k != KIND_NONE)
			stim_count++;
	endtask

	// random bits wherever the window decode does not look
	function automatic logic [23:0] dma_reg(logic [2:0] ch, logic [3:0] ofs);
		logic [15:0] a16;
		a16 = DMA_WIN_BASE | (16'($urandom) & ~DMA_WIN_MASK);
		a16[6:4] = ch;
		a16[3:0] = ofs;
		return {8'($urandom), a16};
	endfunction

	function automatic logic [23:0] dev_reg(logic [15:0] a16);
		return {8'($urandom), a16};
	endfunction

	task automatic check_field(string field, logic [27:0] want, logic [27:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			mismatches++;
		end
	endtask

	// driver: bursts of items with random gaps, pause items wait for the block to drain
	always @(posedge clk or negedge arst_n) begin : drive_access
		outcome_t predicted;
		access_t  nxt;
		int       burst_left;
		int       gap_left;
		if (!arst_n) begin
			access_valid <= 1'b0;
			kind <= KIND_RD;
			address <= '0;
			write_data <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (access_valid && !access_stall) begin
				predicted = predict_access(kind, address, write_data);
				predicted.stamp = $time;
				outcome_q.push_back(predicted);
				accesses_taken++;
			end
			if (access_valid && access_stall) begin
				held_cycles++;
			end else if (gap_left != 0) begin
				gap_left--;
				access_valid <= 1'b0;
			end else if (access_q.size() != 0 && access_q[0].pause) begin
				access_valid <= 1'b0;
				if (outcome_q.size() == 0)
					void'(access_q.pop_front());
			end else if (access_q.size() != 0) begin
				nxt = access_q.pop_front();
				access_valid <= 1'b1;
				kind <= nxt.kind;
				address <= nxt.address;
				write_data <= nxt.write_data;
				if (burst_left <= 1) begin
					burst_left = ($urandom_range(3) == 0) ? $urandom_range(200, 50)
						: $urandom_range(16, 1);
					gap_left = $urandom_range(10);
				end else begin
					burst_left--;
				end
			end else begin
				access_valid <= 1'b0;
			end
		end
	end

	// monitor: check results in order, stall on a shifting pattern plus long hold-offs
	always @(posedge clk or negedge arst_n) begin : check_result
		outcome_t    want;
		stall_mode_t stall_mode;
		int          mode_left;
		int          hold_left;
		int          next_hold;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_mode = STALL_NONE;
			mode_left = 0;
			hold_left = 0;
			next_hold = 150;
		end else begin
			if (result_valid && !result_stall) begin
				if (outcome_q.size() == 0 || outcome_q[0].stamp == $time) begin
					$error("result with no access outstanding: action %0d", action);
					mismatches++;
				end else begin
					want = outcome_q.pop_front();
					check_field("action", want.action, action);
					check_field("read_data", want.read_data, read_data);
					check_field("rom_address", want.rom_address, rom_address);
					check_field("stream_start", want.stream_start, stream_start);
					check_field("channel", want.channel, channel);
					if (want.action == ACT_DECOMP)
						bytes_served++;
					if (want.stream_start)
						streams_started++;
				end
				results_checked++;
			end
			if (hold_left == 0 && results_checked >= next_hold) begin
				hold_left = LONG_HOLD;
				next_hold += 650;
			end
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(3));
				mode_left = $urandom_range(300, 40);
			end else begin
				mode_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				case (stall_mode)
				STALL_NONE:  result_stall <= 1'b0;
				STALL_LIGHT: result_stall <= ($urandom_range(3) == 0);
				STALL_HEAVY: result_stall <= ($urandom_range(3) != 0);
				default:     result_stall <= !result_stall;
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (arst_n && !((access_valid && !access_stall) || (result_valid && !result_stall)))
				idle++;
			else
				idle = 0;
		end
		$display("FAIL rom_bank_map_dma_snoop");
		$finish;
	end

	initial begin : stimulus
		logic [2:0]  ch;
		logic [2:0]  other;
		logic [1:0]  bank;
		logic [23:0] base;
		logic [15:0] len;
		logic [7:0]  mask;
		int          reads;
		int          next_pause;
		stim_count = 0;
		for (int i = 0; i < CHANNELS; i++) begin
			dma_src[i] = '0;
			dma_len[i] = '0;
		end
		for (int i = 0; i < BANKS; i++)
			bank_reg[i] = 8'(i);
		dev_enable = '0;
		xfer_mask = '0;
		in_stream = 1'b0;

		// bank registers at reset, window read, unreadable and unused accesses
		push_access(KIND_RD, {8'h00, REG_BANK0}, 8'h00);
		push_access(KIND_RD, {8'hff, REG_BANK0 + 16'd3}, 8'hff);
		push_access(KIND_RD, dma_reg(3'd0, DMA_ADDR_LO), 8'h00);
		push_access(KIND_RD, {8'h00, REG_DEV_EN}, 8'h00);
		push_access(KIND_NONE, 24'hffffff, 8'hff);
		// upper address bits do not take part in the register decode
		push_access(KIND_WR, {8'hff, REG_BANK0 + 16'd1}, 8'hff);
		push_access(KIND_RD, {8'h12, REG_BANK0 + 16'd1}, 8'h00);
		push_access(KIND_WR, {8'h00, REG_BANK0 + 16'd4}, 8'h55);
		// one-byte stream on the last channel at the top address
		push_access(KIND_WR, dma_reg(3'd7, DMA_ADDR_LO), 8'hff);
		push_access(KIND_WR, dma_reg(3'd7, DMA_ADDR_MID), 8'hff);
		push_access(KIND_WR, dma_reg(3'd7, DMA_ADDR_HI), 8'hff);
		push_access(KIND_WR, dma_reg(3'd7, DMA_CNT_LO), 8'h01);
		push_access(KIND_WR, dma_reg(3'd7, DMA_CNT_HI), 8'h00);
		push_access(KIND_WR, dma_reg(3'd7, DMA_OFS_UNUSED), 8'haa);
		push_access(KIND_WR, {8'h00, REG_DEV_EN}, 8'h80);
		push_access(KIND_WR, {8'h00, REG_XFER_EN}, 8'h80);
		push_access(KIND_ROM, 24'hffffff, 8'h00);
		push_access(KIND_ROM, 24'hffffff, 8'h00);
		push_access(KIND_ROM, 24'h000000, 8'h00);
		push_access(KIND_ROM, ROM_DIRECT_LIMIT - 24'd1, 8'h00);
		push_access(KIND_ROM, 24'h500000, 8'h00);
		// zero size wraps, two channels on one source: lower channel wins
		push_access(KIND_WR, dma_reg(3'd0, DMA_ADDR_HI), 8'h40);
		push_access(KIND_WR, dma_reg(3'd1, DMA_ADDR_HI), 8'h40);
		push_access(KIND_WR, {8'h00, REG_DEV_EN}, 8'h03);
		push_access(KIND_WR, {8'h00, REG_XFER_EN}, 8'h03);
		push_access(KIND_ROM, ROM_DIRECT_LIMIT, 8'h00);
		push_access(KIND_ROM, ROM_DIRECT_LIMIT, 8'h00);
		access_q.push_back('{KIND_RD, 24'h0, 8'h0, 1'b1});

		next_pause = stim_count + PAUSE_STEP;
		while (stim_count < ITEM_GOAL) begin
			case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				ch = 3'($urandom);
				base = 24'($urandom);
				if ($urandom_range(5) != 0 && base < ROM_DIRECT_LIMIT)
					base[23:22] = 2'($urandom_range(3, 1));
				case ($urandom_range(9))
				0:       len = 16'h0000;
				1:       len = 16'($urandom_range(120, 20));
				default: len = 16'($urandom_range(8, 1));
				endcase
				push_access(KIND_WR, dma_reg(ch, DMA_ADDR_LO), base[7:0]);
				push_access(KIND_WR, dma_reg(ch, DMA_ADDR_MID), base[15:8]);
				push_access(KIND_WR, dma_reg(ch, DMA_ADDR_HI), base[23:16]);
				push_access(KIND_WR, dma_reg(ch, DMA_CNT_LO), len[7:0]);
				push_access(KIND_WR, dma_reg(ch, DMA_CNT_HI), len[15:8]);
				mask = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom);
				if (ch != 3'd0 && $urandom_range(3) == 0) begin
					// a lower channel on the same source takes priority
					other = 3'($urandom_range(int'(ch) - 1));
					push_access(KIND_WR, dma_reg(other, DMA_ADDR_LO), base[7:0]);
					push_access(KIND_WR, dma_reg(other, DMA_ADDR_MID), base[15:8]);
					push_access(KIND_WR, dma_reg(other, DMA_ADDR_HI), base[23:16]);
					push_access(KIND_WR, dma_reg(other, DMA_CNT_LO), 8'($urandom_range(4, 1)));
					push_access(KIND_WR, dma_reg(other, DMA_CNT_HI), 8'h00);
					mask[other] = 1'b1;
				end
				mask[ch] = 1'b1;
				push_access(KIND_WR, dev_reg(REG_DEV_EN), mask | 8'($urandom));
				push_access(KIND_WR, dev_reg(REG_XFER_EN), mask);
				reads = (len == 16'h0000) ? $urandom_range(5, 2) : int'(len) + $urandom_range(2);
				repeat (reads) begin
					if ($urandom_range(5) == 0)
						push_access(KIND_RD, dev_reg(REG_BANK0 + 16'($urandom_range(3))),
							8'($urandom));
					push_access(KIND_ROM, base, 8'($urandom));
				end
			end
			6, 7: begin
				repeat ($urandom_range(8, 1)) begin
					case ($urandom_range(5))
					0: push_access(2'($urandom), 24'($urandom), 8'($urandom));
					1: push_access(KIND_RD, dev_reg(REG_DEV_EN + 16'($urandom_range(15))),
						8'($urandom));
					2: push_access(KIND_WR, dma_reg(3'($urandom), 4'($urandom)), 8'($urandom));
					3: push_access(KIND_ROM, 24'($urandom), 8'($urandom));
					4: push_access(KIND_WR, dev_reg(REG_DEV_EN + 16'($urandom_range(7))),
						8'($urandom));
					default: push_access(KIND_RD, 24'($urandom), 8'($urandom));
					endcase
				end
			end
			default: begin
				bank = 2'($urandom);
				base = 24'($urandom);
				base[21:20] = bank;
				if (base < ROM_DIRECT_LIMIT)
					base[22] = 1'b1;
				push_access(KIND_WR, dev_reg(REG_BANK0 + 16'(bank)), 8'($urandom));
				push_access(KIND_RD, dev_reg(REG_BANK0 + 16'(bank)), 8'($urandom));
				push_access(KIND_ROM, base, 8'($urandom));
			end
			endcase
			if (stim_count >= next_pause) begin
				access_q.push_back('{KIND_RD, 24'h0, 8'h0, 1'b1});
				next_pause += PAUSE_STEP;
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (access_q.size() != 0 || access_valid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d results for %0d accesses: %0d decompressor bytes in %0d streams.",
			results_checked, accesses_taken, bytes_served, streams_started);
		$display("Input held off for %0d cycles under receiver back-pressure.", held_cycles);
		if (mismatches == 0)
			$display("PASS rom_bank_map_dma_snoop");
		else
			$display("FAIL rom_bank_map_dma_snoop");
		$finish;
	end

endmodule
